// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the shape raster engine RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BSRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Boolean condition must never be true outside reset.
`define BSRE_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ----- rtl/bsre_pkg.sv -----
// Package for the bitmap shape raster engine: widths, codes, control structs
// and small mask and arithmetic helpers. No dependencies.
`default_nettype none

package bsre_pkg;

  localparam int unsigned CanvasRowsDef = 20;
  localparam int unsigned CanvasColsDef = 40;
  localparam int unsigned FuncW         = 3;
  localparam int unsigned CoordW        = 6;
  localparam int unsigned RowBitsW      = 40;

  typedef enum logic [FuncW-1:0] {
    FN_FILL  = 3'd0,
    FN_LINE  = 3'd1,
    FN_TRI   = 3'd2,
    FN_DISC  = 3'd3,
    FN_ERASE = 3'd4,
    FN_CLEAR = 3'd5,
    FN_READ  = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_READ
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic              load;
    logic              clear_all;
    logic              issue;
    logic              issue_last;
    logic [CoordW-1:0] issue_row;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic s1_busy;
    logic can_issue;
  } dp_stat_t;

  // Bits lo..hi inclusive; empty when hi is below lo.
  function automatic logic [63:0] span_mask(input logic [6:0] lo, input logic [6:0] hi);
    logic [63:0] m;
    m = '0;
    for (int j = 0; j < 64; j++) begin
      m[j] = (7'(j) >= lo) && (7'(j) <= hi);
    end
    return m;
  endfunction

  function automatic logic [CoordW-1:0] abs_diff(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [2*CoordW-1:0] square(input logic [CoordW-1:0] a);
    return (2*CoordW)'(a) * (2*CoordW)'(a);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bsre_if.sv -----
// Request channels of the shape raster engine: drawing commands in, canvas rows out.
// Depends on bsre_pkg for field widths.
`default_nettype none

interface bsre_cmd_if import bsre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [CoordW-1:0] pos_x;
  logic [CoordW-1:0] pos_y;
  logic [CoordW-1:0] end_x;
  logic [CoordW-1:0] end_y;
  logic [CoordW-1:0] width;
  logic [CoordW-1:0] height;
  logic [CoordW-1:0] radius;

  modport source (output valid, func, pos_x, pos_y, end_x, end_y, width, height, radius,
                  input ready);
  modport sink   (input valid, func, pos_x, pos_y, end_x, end_y, width, height, radius,
                  output ready);
endinterface

interface bsre_row_if import bsre_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CoordW-1:0]   row_index;
  logic [RowBitsW-1:0] row_bits;
  logic                last;

  modport source (output valid, row_index, row_bits, last, input ready);
  modport sink   (input valid, row_index, row_bits, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/bsre_ctrl.sv -----
// Sequencer of the shape raster engine: accepts requests and steps the row sweep.
// Depends on bsre_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bsre_ctrl import bsre_pkg::*; #(
  parameter int unsigned CanvasRows = CanvasRowsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [FuncW-1:0] in_func_i,
  output logic             in_ready_o,
  input  dp_stat_t         stat_i,
  output ctl_cmd_t         ctl_o
);

  localparam int unsigned RowW = (CanvasRows > 1) ? $clog2(CanvasRows) : 1;

  state_e          state_q, state_d;
  logic [RowW-1:0] row_q, row_d;
  logic            last_row;

  assign last_row = (row_q == RowW'(CanvasRows - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    row_d            = row_q;
    in_ready_o       = 1'b0;
    ctl_o            = '0;
    ctl_o.issue_row  = CoordW'(row_q);
    unique case (state_q)
      ST_IDLE: begin
        // The previous sweep must have left the pipe before new work starts.
        in_ready_o = !stat_i.s1_busy;
        if (in_valid_i && !stat_i.s1_busy) begin
          ctl_o.load = 1'b1;
          row_d      = '0;
          case (in_func_i) inside
            FN_FILL, FN_LINE, FN_TRI, FN_DISC, FN_ERASE: state_d = ST_DRAW;
            FN_CLEAR: ctl_o.clear_all = 1'b1;
            FN_READ:  state_d = ST_READ;
            default:  ;
          endcase
        end
      end
      ST_DRAW, ST_READ: begin
        if (stat_i.can_issue) begin
          ctl_o.issue      = 1'b1;
          ctl_o.issue_last = last_row;
          if (last_row) begin
            state_d = ST_IDLE;
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `BSRE_ASSERT(a_issue_in_sweep, ctl_o.issue |-> (state_q != ST_IDLE), "row issued while idle")
  `BSRE_ASSERT(a_last_ends_sweep, (ctl_o.issue && ctl_o.issue_last) |=> (state_q == ST_IDLE), "sweep did not end after last row")
  `BSRE_NEVER(a_load_vs_issue, ctl_o.load && ctl_o.issue, "request taken during a sweep")

endmodule

`default_nettype wire

// ----- rtl/bsre_datapath.sv -----
// Datapath of the shape raster engine: command register, canvas memory with row
// valid bits, read-modify-write stage, shape masks and the output register.
// Depends on bsre_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bsre_datapath import bsre_pkg::*; #(
  parameter int unsigned CanvasRows = CanvasRowsDef,
  parameter int unsigned CanvasCols = CanvasColsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_cmd_t            ctl_i,
  output dp_stat_t            stat_o,
  input  logic [FuncW-1:0]    func_i,
  input  logic [CoordW-1:0]   pos_x_i,
  input  logic [CoordW-1:0]   pos_y_i,
  input  logic [CoordW-1:0]   end_x_i,
  input  logic [CoordW-1:0]   end_y_i,
  input  logic [CoordW-1:0]   width_i,
  input  logic [CoordW-1:0]   height_i,
  input  logic [CoordW-1:0]   radius_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [CoordW-1:0]   out_row_index_o,
  output logic [RowBitsW-1:0] out_row_bits_o,
  output logic                out_last_o
);

  localparam int unsigned RowW = (CanvasRows > 1) ? $clog2(CanvasRows) : 1;

  // Command register.
  logic [FuncW-1:0]  func_q;
  logic [CoordW-1:0] pos_x_q, pos_y_q, end_x_q, end_y_q, width_q, height_q, radius_q;

  // Canvas storage. A row whose valid bit is clear reads as blank.
  logic [CanvasCols-1:0] canvas_q [CanvasRows];
  logic [CanvasRows-1:0] vld_q;

  // Read stage.
  logic                  s1_v_q;
  logic [RowW-1:0]       s1_row_q;
  logic                  s1_last_q;
  logic [CanvasCols-1:0] rdata_q;
  logic                  rvld_q;

  // Output register.
  logic                  out_v_q;
  logic [CoordW-1:0]     out_row_q;
  logic [RowBitsW-1:0]   out_bits_q;
  logic                  out_last_q;

  logic [RowW-1:0]       issue_row;
  logic                  read_mode;
  logic                  s1_adv;
  logic                  wr_en;
  logic                  out_load;
  logic [CanvasCols-1:0] cur_row;
  logic [CanvasCols-1:0] mask;
  logic [CanvasCols-1:0] new_row;
  logic [63:0]           cur_wide;

  assign issue_row = ctl_i.issue_row[RowW-1:0];
  assign read_mode = (func_q == FN_READ);
  assign s1_adv    = s1_v_q && (!read_mode || !out_v_q || out_ready_i);
  assign wr_en     = s1_v_q && !read_mode;
  assign out_load  = s1_adv && read_mode;
  assign cur_row   = rvld_q ? rdata_q : '0;
  assign cur_wide  = 64'(cur_row);

  assign stat_o.s1_busy   = s1_v_q;
  assign stat_o.can_issue = !s1_v_q || s1_adv;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      func_q   <= func_i;
      pos_x_q  <= pos_x_i;
      pos_y_q  <= pos_y_i;
      end_x_q  <= end_x_i;
      end_y_q  <= end_y_i;
      width_q  <= width_i;
      height_q <= height_i;
      radius_q <= radius_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      canvas_q[s1_row_q] <= new_row;
    end
    if (ctl_i.issue) begin
      rdata_q <= canvas_q[issue_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.clear_all) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[s1_row_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (ctl_i.issue) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      s1_row_q  <= issue_row;
      s1_last_q <= ctl_i.issue_last;
      rvld_q    <= vld_q[issue_row];
    end
  end

  // Per-row shape mask for the row in the read stage.
  always_comb begin
    logic [6:0]          row7, px7, py7, ex7, ey7, w7, h7;
    logic [63:0]         span;
    logic                hit;
    logic [CoordW-1:0]   dy;
    logic [2*CoordW-1:0] dy2, r2;
    logic [CanvasCols-1:0] disc_bits;
    row7 = 7'(s1_row_q);
    px7  = 7'(pos_x_q);
    py7  = 7'(pos_y_q);
    ex7  = 7'(end_x_q);
    ey7  = 7'(end_y_q);
    w7   = 7'(width_q);
    h7   = 7'(height_q);
    hit  = 1'b0;
    span = '0;
    dy   = abs_diff(CoordW'(s1_row_q), pos_y_q);
    dy2  = square(dy);
    r2   = square(radius_q);
    for (int j = 0; j < CanvasCols; j++) begin
      disc_bits[j] = ((2*CoordW+1)'(square(abs_diff(CoordW'(j), pos_x_q))) +
                      (2*CoordW+1)'(dy2)) <= (2*CoordW+1)'(r2);
    end
    case (func_q) inside
      FN_FILL, FN_ERASE: begin
        hit  = (w7 != 7'd0) && (h7 != 7'd0) && (row7 >= py7) && (row7 < py7 + h7);
        span = span_mask(px7, px7 + w7 - 7'd1);
      end
      FN_LINE: begin
        // A horizontal match takes priority over a vertical one.
        if (py7 == ey7) begin
          hit  = (row7 == py7);
          span = span_mask(px7, ex7);
        end else if (px7 == ex7) begin
          hit  = (row7 >= py7) && (row7 <= ey7);
          span = span_mask(px7, px7);
        end
      end
      FN_TRI: begin
        hit  = (row7 >= py7) && ((row7 - py7) < h7);
        span = span_mask(px7, px7 + (row7 - py7));
      end
      default: ;
    endcase
    if (func_q == FN_DISC) begin
      mask = disc_bits;
    end else begin
      mask = hit ? span[CanvasCols-1:0] : '0;
    end
  end

  assign new_row = (func_q == FN_ERASE) ? (cur_row & ~mask) : (cur_row | mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q  <= CoordW'(s1_row_q);
      out_bits_q <= cur_wide[RowBitsW-1:0];
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign out_row_index_o = out_row_q;
  assign out_row_bits_o  = out_bits_q;
  assign out_last_o      = out_last_q;

  `BSRE_ASSERT(a_issue_fills_s1, ctl_i.issue |=> s1_v_q, "issued row missing from read stage")
  `BSRE_ASSERT(a_last_is_bottom, (out_v_q && out_last_q) |-> (out_row_q == CoordW'(CanvasRows - 1)), "last flag on wrong row")
  `BSRE_NEVER(a_write_vs_output, wr_en && out_load, "canvas write during readout")
  `BSRE_NEVER(a_load_while_busy, ctl_i.load && s1_v_q, "command loaded with a row in flight")

endmodule

`default_nettype wire

// ----- rtl/bitmap_shape_raster_engine.sv -----
// Top level of the bitmap shape raster engine: sequencer plus datapath.
// Depends on bsre_pkg, bsre_if, bsre_ctrl and bsre_datapath.
//
//   channel | dir | payload                                         | per request
//   cmd_i   | in  | func pos_x pos_y end_x end_y width height radius | one command
//   row_o   | out | row_index row_bits last                          | one canvas row
//
// Drawing commands sweep every canvas row through a read-modify-write pipe on the
// canvas memory, one row per cycle. Between one accepted command and the next come
// the accept, the sweep, and the drain of the last row from the read stage.
// A readout streams CANVAS_ROWS rows, one per cycle while row_o is ready; a stall
// on row_o holds the sweep. Clear all and the unused code start no sweep.
// Reset clears the per-row valid bits but not the canvas memory; a row never written reads as blank.
`default_nettype none

module bitmap_shape_raster_engine import bsre_pkg::*; #(
  parameter int unsigned CANVAS_ROWS = CanvasRowsDef,
  parameter int unsigned CANVAS_COLS = CanvasColsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsre_cmd_if.sink   cmd_i,
  bsre_row_if.source row_o
);

  ctl_cmd_t ctl;
  dp_stat_t stat;
  logic     in_ready;

  assign cmd_i.ready = in_ready;

  bsre_ctrl #(
    .CanvasRows (CANVAS_ROWS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_func_i  (cmd_i.func),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  bsre_datapath #(
    .CanvasRows (CANVAS_ROWS),
    .CanvasCols (CANVAS_COLS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .func_i          (cmd_i.func),
    .pos_x_i         (cmd_i.pos_x),
    .pos_y_i         (cmd_i.pos_y),
    .end_x_i         (cmd_i.end_x),
    .end_y_i         (cmd_i.end_y),
    .width_i         (cmd_i.width),
    .height_i        (cmd_i.height),
    .radius_i        (cmd_i.radius),
    .out_ready_i     (row_o.ready),
    .out_valid_o     (row_o.valid),
    .out_row_index_o (row_o.row_index),
    .out_row_bits_o  (row_o.row_bits),
    .out_last_o      (row_o.last)
  );

endmodule

`default_nettype wire
